### design/qrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared widths, stage counts and constants of the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qrv_pkg;

    // field widths
    localparam int DW        = 16;
    localparam int FRAC_BITS = 14;
    localparam int INV_BITS  = 16;
    localparam int OUT_SHIFT = FRAC_BITS + INV_BITS;

    // norm: sum of four squares, its root, the norm with one LSB of epsilon
    localparam int SQ_W   = 2 * DW + 1;
    localparam int ROOT_W = DW + 1;
    localparam int NRM_W  = DW + 1;

    // divider: |part| * 2^INV_BITS plus half the norm over the norm
    localparam int NUM_W  = DW + INV_BITS;
    localparam int QT_W   = INV_BITS + 1;
    localparam int DREM_W = NRM_W + QT_W - 1;
    localparam int IQ_W   = QT_W + 1;

    // products
    localparam int H1_W  = DW + 1;
    localparam int R_W   = 2 * H1_W;
    localparam int AS_W  = R_W + 1;
    localparam int BS_W  = IQ_W + 1;
    localparam int LO_W  = 18;
    localparam int HI_W  = AS_W - LO_W;
    localparam int PLO_W = 2 * BS_W;
    localparam int PHI_W = HI_W + BS_W;
    localparam int P2_W  = AS_W + BS_W;
    localparam int F_W   = P2_W + 3;
    localparam int QV_W  = F_W + 1 - OUT_SHIFT;

    // pipeline depth
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QT_W;
    localparam int RDLY        = SQRT_STAGES + 1 + DIV_STAGES + 1;
    localparam int PIPE_STAGES = 2 + SQRT_STAGES + 1 + DIV_STAGES + 7;

    // saturation limits
    localparam int MAG_POS_MAX = 2 ** (DW - 1) - 1;
    localparam int MAG_NEG_MAX = 2 ** (DW - 1);

    typedef logic signed [DW-1:0] t_s16;

    localparam t_s16 S16_MAX = 16'sh7FFF;
    localparam t_s16 S16_MIN = 16'sh8000;

endpackage

### design/qrv_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrv_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qrv_pkg::SQ_W-1:0]       i_s,
    output logic [qrv_pkg::ROOT_W-1:0]     o_root
);

    localparam int ROOT_W = qrv_pkg::ROOT_W;
    localparam int REM_W  = qrv_pkg::SQ_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    // stage g settles root bit ROOT_W-1-g
    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int B = ROOT_W - 1 - g;
        logic [REM_W-1:0]  w_rem_in;
        logic [REM_W-1:0]  w_trial;
        logic [ROOT_W-1:0] w_root_in;
        logic              w_take;

        if (g == 0) begin : g_first
            assign w_rem_in  = REM_W'(i_s);
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
        end

        // (root + 2^B)^2 - root^2
        assign w_trial = (REM_W'(w_root_in) << (B + 1)) + (REM_W'(1) << (2 * B));
        assign w_take  = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[g] <= w_take ? (w_root_in | (ROOT_W'(1) << B)) : w_root_in;
            end
        end

        // the final stage needs no remainder
        if (g < ROOT_W - 1) begin : g_rem
            logic [REM_W-1:0] n_rem;
            assign n_rem = w_take ? (w_rem_in - w_trial) : w_rem_in;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

### design/qrv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_div
// Four-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module qrv_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qrv_pkg::NUM_W-1:0]      i_num [4],
    input  logic [qrv_pkg::NRM_W-1:0]      i_den,
    output logic [qrv_pkg::QT_W-1:0]       o_quo [4]
);

    localparam int QT_W   = qrv_pkg::QT_W;
    localparam int NRM_W  = qrv_pkg::NRM_W;
    localparam int DREM_W = qrv_pkg::DREM_W;

    logic [DREM_W-1:0] r_rem [QT_W-1][4];
    logic [NRM_W-1:0]  r_den [QT_W-1];
    logic [QT_W-1:0]   r_quo [QT_W][4];

    for (genvar g = 0; g < QT_W; g++) begin : g_stage
        localparam int B = QT_W - 1 - g;
        logic [DREM_W-1:0] w_rem_in [4];
        logic [QT_W-1:0]   w_quo_in [4];
        logic [NRM_W-1:0]  w_den;
        logic [DREM_W-1:0] w_trial;
        logic [3:0]        w_take;

        if (g == 0) begin : g_first
            assign w_den = i_den;
            for (genvar l = 0; l < 4; l++) begin : g_lane
                assign w_rem_in[l] = DREM_W'(i_num[l]);
                assign w_quo_in[l] = '0;
            end
        end else begin : g_next
            assign w_den = r_den[g-1];
            for (genvar l = 0; l < 4; l++) begin : g_lane
                assign w_rem_in[l] = r_rem[g-1][l];
                assign w_quo_in[l] = r_quo[g-1][l];
            end
        end

        assign w_trial = DREM_W'(w_den) << B;

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                w_take[l] = (w_rem_in[l] >= w_trial);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 4; l++) begin
                    r_quo[g][l] <= w_take[l] ? (w_quo_in[l] | (QT_W'(1) << B))
                                             : w_quo_in[l];
                end
            end
        end

        // remainder and divisor move on except after the last bit
        if (g < QT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[g] <= w_den;
                    for (int l = 0; l < 4; l++) begin
                        r_rem[g][l] <= w_take[l] ? (w_rem_in[l] - w_trial) : w_rem_in[l];
                    end
                end
            end
        end
    end

    assign o_quo = r_quo[QT_W-1];

endmodule

### design/quaternion_rotate_vector_top.sv
`timescale 1ns / 1ps
// Rotates a 16-bit vector by a Q1.14 quaternion, v' = q v q^-1, with the
// inverse taken as the conjugate over (|q| + 1 LSB). One beat is accepted per
// clock while o_s_tready is high; a result passes 44 pipeline stages and then
// the output register, the depth being set by the 17-stage square root and the
// 17-stage divider. Beats leave in input order.
// A skid register behind the output lets the pipeline finish one more beat
// while the sink stalls; only when that register is full does the input
// stall, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_top
// Pipelined quaternion rotation of a 3-vector with rounding and saturation.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, 16 bits each
    input  logic [111:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // rot_x, rot_y, rot_z, 16 bits each
    output logic [47:0]  o_m_tdata,
    // saturated
    output logic         o_m_tuser
);

    localparam int DW     = qrv_pkg::DW;
    localparam int H1_W   = qrv_pkg::H1_W;
    localparam int R_W    = qrv_pkg::R_W;
    localparam int AS_W   = qrv_pkg::AS_W;
    localparam int BS_W   = qrv_pkg::BS_W;
    localparam int LO_W   = qrv_pkg::LO_W;
    localparam int PLO_W  = qrv_pkg::PLO_W;
    localparam int PHI_W  = qrv_pkg::PHI_W;
    localparam int P2_W   = qrv_pkg::P2_W;
    localparam int F_W    = qrv_pkg::F_W;
    localparam int QV_W   = qrv_pkg::QV_W;
    localparam int IQ_W   = qrv_pkg::IQ_W;
    localparam int NRM_W  = qrv_pkg::NRM_W;
    localparam int NUM_W  = qrv_pkg::NUM_W;
    localparam int QT_W   = qrv_pkg::QT_W;
    localparam int SQ_W   = qrv_pkg::SQ_W;
    localparam int NST    = qrv_pkg::PIPE_STAGES;
    localparam int SQD    = qrv_pkg::SQRT_STAGES;
    localparam int DVD    = qrv_pkg::DIV_STAGES;
    localparam int RDLY   = qrv_pkg::RDLY;
    localparam int OSH    = qrv_pkg::OUT_SHIFT;

    // pipeline control
    logic           w_en;
    logic [NST-1:0] r_vld;

    // input unpack
    qrv_pkg::t_s16 w_q [4];
    qrv_pkg::t_s16 w_v [3];

    assign w_q[0] = i_s_tdata[15:0];
    assign w_q[1] = i_s_tdata[31:16];
    assign w_q[2] = i_s_tdata[47:32];
    assign w_q[3] = i_s_tdata[63:48];
    assign w_v[0] = i_s_tdata[79:64];
    assign w_v[1] = i_s_tdata[95:80];
    assign w_v[2] = i_s_tdata[111:96];

    // ---- stage 1: squares and first product factors ----
    logic signed [H1_W-1:0] w_a1 [8];
    logic signed [H1_W-1:0] w_b1 [8];
    logic [SQ_W-1:0]        r_sq [4];
    logic signed [R_W-1:0]  r_p1 [8];
    qrv_pkg::t_s16          r_q1 [4];

    // q * (0, v): factor sums of the eight-multiply form
    assign w_a1[0] = H1_W'(w_q[0]) + H1_W'(w_q[1]);
    assign w_a1[1] = H1_W'(w_q[3]) - H1_W'(w_q[2]);
    assign w_a1[2] = H1_W'(w_q[0]) - H1_W'(w_q[1]);
    assign w_a1[3] = H1_W'(w_q[2]) + H1_W'(w_q[3]);
    assign w_a1[4] = H1_W'(w_q[1]) + H1_W'(w_q[3]);
    assign w_a1[5] = H1_W'(w_q[1]) - H1_W'(w_q[3]);
    assign w_a1[6] = H1_W'(w_q[0]) + H1_W'(w_q[2]);
    assign w_a1[7] = H1_W'(w_q[0]) - H1_W'(w_q[2]);

    assign w_b1[0] = H1_W'(w_v[0]);
    assign w_b1[1] = H1_W'(w_v[1]) - H1_W'(w_v[2]);
    assign w_b1[2] = H1_W'(w_v[1]) + H1_W'(w_v[2]);
    assign w_b1[3] = -H1_W'(w_v[0]);
    assign w_b1[4] = H1_W'(w_v[0]) + H1_W'(w_v[1]);
    assign w_b1[5] = H1_W'(w_v[0]) - H1_W'(w_v[1]);
    assign w_b1[6] = -H1_W'(w_v[2]);
    assign w_b1[7] = H1_W'(w_v[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= SQ_W'(unsigned'(R_W'(w_q[i] * w_q[i])));
                r_q1[i] <= w_q[i];
            end
            for (int k = 0; k < 8; k++) begin
                r_p1[k] <= w_a1[k] * w_b1[k];
            end
        end
    end

    // ---- stage 2: sum of squares, first product r = q v ----
    logic [SQ_W-1:0]          r_s;
    logic signed [R_W-1:0]    r_r [4];
    qrv_pkg::t_s16            r_q2 [4];
    logic signed [R_W+1:0]    w_h1 [4];

    always_comb begin
        w_h1[0] = (R_W+2)'(r_p1[1]) + ((-(R_W+2)'(r_p1[4]) - (R_W+2)'(r_p1[5])
                  + (R_W+2)'(r_p1[6]) + (R_W+2)'(r_p1[7])) >>> 1);
        w_h1[1] = (R_W+2)'(r_p1[0]) - (((R_W+2)'(r_p1[4]) + (R_W+2)'(r_p1[5])
                  + (R_W+2)'(r_p1[6]) + (R_W+2)'(r_p1[7])) >>> 1);
        w_h1[2] = (R_W+2)'(r_p1[2]) + (((R_W+2)'(r_p1[4]) - (R_W+2)'(r_p1[5])
                  + (R_W+2)'(r_p1[6]) - (R_W+2)'(r_p1[7])) >>> 1);
        w_h1[3] = (R_W+2)'(r_p1[3]) + (((R_W+2)'(r_p1[4]) - (R_W+2)'(r_p1[5])
                  - (R_W+2)'(r_p1[6]) + (R_W+2)'(r_p1[7])) >>> 1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s <= r_sq[0] + r_sq[1] + r_sq[2] + r_sq[3];
            for (int i = 0; i < 4; i++) begin
                r_r[i]  <= R_W'(w_h1[i]);
                r_q2[i] <= r_q1[i];
            end
        end
    end

    // ---- square root of the sum of squares ----
    logic [qrv_pkg::ROOT_W-1:0] w_root;

    qrv_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_s    (r_s),
        .o_root (w_root)
    );

    // quaternion parts and first product wait beside the root and divider
    qrv_pkg::t_s16         r_qdl [SQD][4];
    logic signed [R_W-1:0] r_rdl [RDLY][4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qdl[0] <= r_q2;
            for (int k = 1; k < SQD; k++) begin
                r_qdl[k] <= r_qdl[k-1];
            end
            r_rdl[0] <= r_r;
            for (int k = 1; k < RDLY; k++) begin
                r_rdl[k] <= r_rdl[k-1];
            end
        end
    end

    // ---- norm and rounded numerators of the inverse ----
    logic [NRM_W-1:0] w_nrm;
    logic [DW-1:0]    w_mag [4];
    logic [NUM_W-1:0] r_num [4];
    logic [NRM_W-1:0] r_den;
    logic [3:0]       r_neg;

    assign w_nrm = w_root + NRM_W'(1);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = r_qdl[SQD-1][i][DW-1] ? DW'(-r_qdl[SQD-1][i]) : DW'(r_qdl[SQD-1][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den <= w_nrm;
            for (int i = 0; i < 4; i++) begin
                r_num[i] <= {w_mag[i], qrv_pkg::INV_BITS'(0)} + NUM_W'(w_nrm >> 1);
            end
            // conjugate: the vector parts change sign
            r_neg[0] <= r_qdl[SQD-1][0][DW-1];
            for (int i = 1; i < 4; i++) begin
                r_neg[i] <= ~r_qdl[SQD-1][i][DW-1];
            end
        end
    end

    logic [QT_W-1:0] w_quo [4];

    qrv_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_quo  (w_quo)
    );

    logic [3:0] r_ndl [DVD];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ndl[0] <= r_neg;
            for (int k = 1; k < DVD; k++) begin
                r_ndl[k] <= r_ndl[k-1];
            end
        end
    end

    // ---- stage A: signed inverse ----
    logic signed [IQ_W-1:0] r_iq [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_iq[i] <= r_ndl[DVD-1][i] ? -signed'(IQ_W'(w_quo[i]))
                                           : signed'(IQ_W'(w_quo[i]));
            end
        end
    end

    // ---- stage B: factor sums of r * q^-1 (products a, c..h) ----
    logic signed [AS_W-1:0] r_as [7];
    logic signed [BS_W-1:0] r_bs [7];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_as[0] <= AS_W'(r_rdl[RDLY-1][0]) + AS_W'(r_rdl[RDLY-1][1]);
            r_as[1] <= AS_W'(r_rdl[RDLY-1][0]) - AS_W'(r_rdl[RDLY-1][1]);
            r_as[2] <= AS_W'(r_rdl[RDLY-1][2]) + AS_W'(r_rdl[RDLY-1][3]);
            r_as[3] <= AS_W'(r_rdl[RDLY-1][1]) + AS_W'(r_rdl[RDLY-1][3]);
            r_as[4] <= AS_W'(r_rdl[RDLY-1][1]) - AS_W'(r_rdl[RDLY-1][3]);
            r_as[5] <= AS_W'(r_rdl[RDLY-1][0]) + AS_W'(r_rdl[RDLY-1][2]);
            r_as[6] <= AS_W'(r_rdl[RDLY-1][0]) - AS_W'(r_rdl[RDLY-1][2]);
            r_bs[0] <= BS_W'(r_iq[0]) + BS_W'(r_iq[1]);
            r_bs[1] <= BS_W'(r_iq[2]) + BS_W'(r_iq[3]);
            r_bs[2] <= BS_W'(r_iq[0]) - BS_W'(r_iq[1]);
            r_bs[3] <= BS_W'(r_iq[1]) + BS_W'(r_iq[2]);
            r_bs[4] <= BS_W'(r_iq[1]) - BS_W'(r_iq[2]);
            r_bs[5] <= BS_W'(r_iq[0]) - BS_W'(r_iq[3]);
            r_bs[6] <= BS_W'(r_iq[0]) + BS_W'(r_iq[3]);
        end
    end

    // ---- stage C: partial products, wide factor split low / high ----
    logic signed [PLO_W-1:0] r_plo [7];
    logic signed [PHI_W-1:0] r_phi [7];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 7; k++) begin
                r_plo[k] <= signed'({1'b0, r_as[k][LO_W-1:0]}) * r_bs[k];
                r_phi[k] <= signed'(r_as[k][AS_W-1:LO_W]) * r_bs[k];
            end
        end
    end

    // ---- stage D: full products ----
    logic signed [P2_W-1:0] r_p2 [7];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 7; k++) begin
                r_p2[k] <= (P2_W'(r_phi[k]) <<< LO_W) + P2_W'(r_plo[k]);
            end
        end
    end

    // ---- stage E: vector part of the second product ----
    logic signed [F_W-1:0] r_f [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f[0] <= F_W'(r_p2[0]) - ((F_W'(r_p2[3]) + F_W'(r_p2[4])
                      + F_W'(r_p2[5]) + F_W'(r_p2[6])) >>> 1);
            r_f[1] <= F_W'(r_p2[1]) + ((F_W'(r_p2[3]) - F_W'(r_p2[4])
                      + F_W'(r_p2[5]) - F_W'(r_p2[6])) >>> 1);
            r_f[2] <= F_W'(r_p2[2]) + ((F_W'(r_p2[3]) - F_W'(r_p2[4])
                      - F_W'(r_p2[5]) + F_W'(r_p2[6])) >>> 1);
        end
    end

    // ---- stage F: sign and magnitude ----
    logic [F_W-1:0] r_fmag [3];
    logic [2:0]     r_fneg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_fneg[i] <= r_f[i][F_W-1];
                r_fmag[i] <= r_f[i][F_W-1] ? unsigned'(-r_f[i]) : unsigned'(r_f[i]);
            end
        end
    end

    // ---- stage G: round half away from zero, clamp ----
    logic [F_W:0]    w_rsum [3];
    logic [QV_W-1:0] w_qv   [3];
    logic [2:0]      w_clip;
    qrv_pkg::t_s16   r_rot  [3];
    logic            r_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rsum[i] = (F_W+1)'(r_fmag[i]) + ((F_W+1)'(1) << (OSH - 1));
            w_qv[i]   = w_rsum[i][F_W:OSH];
            w_clip[i] = r_fneg[i] ? (w_qv[i] > QV_W'(qrv_pkg::MAG_NEG_MAX))
                                  : (w_qv[i] > QV_W'(qrv_pkg::MAG_POS_MAX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_clip[i]) begin
                    r_rot[i] <= r_fneg[i] ? qrv_pkg::S16_MIN : qrv_pkg::S16_MAX;
                end else begin
                    r_rot[i] <= r_fneg[i] ? -signed'(w_qv[i][DW-1:0])
                                          : signed'(w_qv[i][DW-1:0]);
                end
            end
            r_sat <= |w_clip;
        end
    end

    // ---- valid bits travel with the stages ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    // ---- output register with skid ----
    logic        r_m_vld;
    logic [47:0] r_m_data;
    logic        r_m_sat;
    logic        r_skid_vld;
    logic [47:0] r_skid_data;
    logic        r_skid_sat;

    assign w_en = ~r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld    <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[NST-1]) begin
            if (r_m_vld && !i_m_tready) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_m_vld <= 1'b1;
            end
        end else if (i_m_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    // payload follows the same choices
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_m_tready) begin
                r_m_data <= r_skid_data;
                r_m_sat  <= r_skid_sat;
            end
        end else if (r_vld[NST-1]) begin
            if (r_m_vld && !i_m_tready) begin
                r_skid_data <= {r_rot[2], r_rot[1], r_rot[0]};
                r_skid_sat  <= r_sat;
            end else begin
                r_m_data <= {r_rot[2], r_rot[1], r_rot[0]};
                r_m_sat  <= r_sat;
            end
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_sat;

`ifndef ASSERT_OFF
    // skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_m_vld)
        else $error("skid holds a beat while the output register is empty");

    // a clipped result sits on a rail
    a_sat_on_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_vld && r_m_sat) |->
            (r_m_data[15:0] == 16'h7FFF || r_m_data[15:0] == 16'h8000 ||
             r_m_data[31:16] == 16'h7FFF || r_m_data[31:16] == 16'h8000 ||
             r_m_data[47:32] == 16'h7FFF || r_m_data[47:32] == 16'h8000))
        else $error("saturation flag without a clipped component");

    // an accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule

### tb/quaternion_rotate_vector_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_top_test
// Drives quaternion and vector beats into the rotator, predicts each rotated
// and saturated vector in exact integer arithmetic, and checks every output
// beat in order, under random gaps on both sides and one long sink stall.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_top_test;

    typedef struct packed {
        logic              sat;
        logic signed [15:0] rz;
        logic signed [15:0] ry;
        logic signed [15:0] rx;
    } t_rot;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [111:0] i_s_tdata = '0;
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [47:0]  o_m_tdata;
    logic         o_m_tuser;

    t_rot        rot_expected[$];
    int unsigned n_errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_sat = 0;
    int unsigned cycle = 0;
    int unsigned gap_pct = 16;
    bit          sink_hold = 1'b0;

    quaternion_rotate_vector_top uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // integer square root, floor
    function automatic longint isqrt(input longint s);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > s) b = b >>> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint round_div(input longint n, input longint d);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m + d / 2) / d;
        return (n < 0) ? -m : m;
    endfunction

    function automatic longint round_shift(input longint n, input int s);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (n < 0) ? -m : m;
    endfunction

    // eight-multiply quaternion product, parts w, x, y, z
    task automatic qmul(input longint a[4], input longint b[4], output longint o[4]);
        longint pa, pb, pc, pd, pe, pf, pg, ph;
        pa = (a[0] + a[1]) * (b[0] + b[1]);
        pb = (a[3] - a[2]) * (b[2] - b[3]);
        pc = (a[0] - a[1]) * (b[2] + b[3]);
        pd = (a[2] + a[3]) * (b[0] - b[1]);
        pe = (a[1] + a[3]) * (b[1] + b[2]);
        pf = (a[1] - a[3]) * (b[1] - b[2]);
        pg = (a[0] + a[2]) * (b[0] - b[3]);
        ph = (a[0] - a[2]) * (b[0] + b[3]);
        o[0] = pb + (-pe - pf + pg + ph) / 2;
        o[1] = pa - (pe + pf + pg + ph) / 2;
        o[2] = pc + (pe - pf + pg - ph) / 2;
        o[3] = pd + (pe - pf - pg + ph) / 2;
    endtask

    task automatic predict_rotation(input logic [111:0] d, output t_rot r);
        longint q[4], v[4], iq[4], t[4], f[4], c[4];
        longint s, nrm;
        s = 0;
        for (int i = 0; i < 4; i++) begin
            q[i] = longint'($signed(d[16*i +: 16]));
            s += q[i] * q[i];
        end
        v[0] = 0;
        for (int i = 1; i < 4; i++) v[i] = longint'($signed(d[16*(i+3) +: 16]));
        nrm = isqrt(s) + 1;
        iq[0] = round_div(q[0] <<< qrv_pkg::INV_BITS, nrm);
        for (int i = 1; i < 4; i++) iq[i] = round_div(-(q[i] <<< qrv_pkg::INV_BITS), nrm);
        qmul(q, v, t);
        qmul(t, iq, f);
        r.sat = 1'b0;
        for (int i = 1; i < 4; i++) begin
            c[i] = round_shift(f[i], qrv_pkg::OUT_SHIFT);
            if (c[i] > 32767) begin
                c[i] = 32767;
                r.sat = 1'b1;
            end else if (c[i] < -32768) begin
                c[i] = -32768;
                r.sat = 1'b1;
            end
        end
        r.rx = c[1][15:0];
        r.ry = c[2][15:0];
        r.rz = c[3][15:0];
    endtask

    task automatic report(input string what, input t_rot got, input t_rot want);
        n_errors++;
        $display("mismatch %s beat %0d: got %0d %0d %0d sat %0b, want %0d %0d %0d sat %0b",
                 what, n_checked, got.rx, got.ry, got.rz, got.sat,
                 want.rx, want.ry, want.rz, want.sat);
    endtask

    // send one beat; random gaps ahead of it
    task automatic send_beat(input logic [111:0] d);
        t_rot r;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        predict_rotation(d, r);
        rot_expected.push_back(r);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_sent++;
    endtask

    function automatic logic [111:0] pack_beat(input logic [15:0] w, x, y, z,
                                               input logic [15:0] vx, vy, vz);
        return {vz, vy, vx, z, y, x, w};
    endfunction

    function automatic logic [15:0] rnd_q();
        // mostly parts within plus or minus one in Q1.14, some anywhere
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // sink: random stalls, or held off as asked
    always @(posedge i_clk) begin
        if (sink_hold) i_m_tready <= 1'b0;
        else i_m_tready <= (gap_pct == 0) || ($urandom_range(99) >= gap_pct);
    end

    // output checker
    always @(posedge i_clk) begin
        t_rot got, want;
        cycle <= cycle + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata};
            if (rot_expected.size() == 0) begin
                n_errors++;
                $display("unexpected output beat %0d", n_checked);
            end else begin
                want = rot_expected.pop_front();
                if (got.rx !== want.rx) report("rot_x", got, want);
                if (got.ry !== want.ry) report("rot_y", got, want);
                if (got.rz !== want.rz) report("rot_z", got, want);
                if (got.sat !== want.sat) report("saturated", got, want);
                if (want.sat) n_sat++;
            end
            n_checked++;
        end
        if (cycle > 400000) begin
            $display("timeout with %0d beats outstanding", rot_expected.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_extremes();
        logic [15:0] e[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        // zero quaternion
        send_beat(pack_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            16'h7FFF, 16'h8000, 16'h1234));
        // identity
        send_beat(pack_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000,
                            16'h7FFF, 16'h8000, 16'h0001));
        send_beat(pack_beat(16'h0000, 16'h4000, 16'h0000, 16'h0000,
                            16'd100, 16'd200, 16'd300));
        send_beat(pack_beat(16'h0000, 16'h0000, 16'h4000, 16'h0000,
                            16'd100, 16'd200, 16'd300));
        send_beat(pack_beat(16'h0000, 16'h0000, 16'h0000, 16'h4000,
                            16'd100, 16'd200, 16'd300));
        // 90 degrees
        send_beat(pack_beat(16'h2D41, 16'h2D41, 16'h0000, 16'h0000,
                            16'd1000, -16'sd1000, 16'd500));
        for (int i = 0; i < 4; i++)
            send_beat(pack_beat(e[i], e[(i+1)%4], e[(i+2)%4], e[(i+3)%4],
                                e[i], e[(i+3)%4], e[(i+1)%4]));
        send_beat(pack_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000));
        send_beat(pack_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF));
        // grows, clips
        send_beat(pack_beat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                            16'h7FFF, 16'h7FFF, 16'h8000));
        // tiny quaternion
        send_beat(pack_beat(16'h0001, 16'h0000, 16'h0000, 16'h0000,
                            16'h7FFF, 16'h0001, 16'hFFFF));
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_beat(pack_beat(rnd_q(), rnd_q(), rnd_q(), rnd_q(),
                                16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    task automatic test_back_pressure();
        // sink held while the source keeps offering beats
        fork
            begin
                sink_hold = 1'b1;
                repeat (150) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            test_random(120);
        join
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(300);
        gap_pct = 0;            // stretch with no gaps
        test_random(150);
        gap_pct = 16;
        test_back_pressure();
        test_random(230);
        i_s_tvalid <= 1'b0;
        while (rot_expected.size() != 0) @(posedge i_clk);
        repeat (qrv_pkg::PIPE_STAGES + 20) @(posedge i_clk);
        $display("covered %0d beats: extremes, zero and non-unit quaternions,", n_sent);
        $display("random and gap-free streams, long sink stall; %0d saturated", n_sat);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### quaternion_rotate_vector_top.f
design/qrv_pkg.sv
design/qrv_sqrt.sv
design/qrv_div.sv
design/quaternion_rotate_vector_top.sv
tb/quaternion_rotate_vector_top_test.sv
